>>> hw/rtl/double_floored_modulo_defines.svh
// ----------------------------------------------------------------------------
// double_floored_modulo_defines: assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_FLOORED_MODULO_DEFINES_SVH
`define DOUBLE_FLOORED_MODULO_DEFINES_SVH

// same-cycle implication
`define DFM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfm assertion failed");

// next-cycle implication
`define DFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfm assertion failed");

`endif

>>> hw/rtl/dfm_pkg.sv
// ----------------------------------------------------------------------------
// dfm_pkg: shared constants
// Binary64 field layout and datapath widths.
// ----------------------------------------------------------------------------
package dfm_pkg;
  localparam int FP_W   = 64;
  localparam int MAG_W  = 63;
  localparam int EXP_W  = 11;
  localparam int FRAC_W = 52;
  localparam int ALU_W  = 56;  // 53-bit mantissa plus guard, round, sticky

  localparam logic [FP_W-1:0]  QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [MAG_W-1:0] EXP_INF   = 63'h7FF0_0000_0000_0000;
  localparam logic [EXP_W-1:0] EXP_ONES  = 11'h7FF;
endpackage

>>> hw/rtl/dfm_in_if.sv
// ----------------------------------------------------------------------------
// dfm_in_if: operand channel
// Valid/ready channel carrying dividend and divisor bit patterns.
// ----------------------------------------------------------------------------
interface dfm_in_if import dfm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [FP_W-1:0] dividend_bits;
  logic [FP_W-1:0] divisor_bits;

  modport source (output valid, output dividend_bits, output divisor_bits, input ready);
  modport sink   (input valid, input dividend_bits, input divisor_bits, output ready);
endinterface

>>> hw/rtl/dfm_out_if.sv
// ----------------------------------------------------------------------------
// dfm_out_if: result channel
// Valid/ready channel carrying the remainder and the invalid flag.
// ----------------------------------------------------------------------------
interface dfm_out_if import dfm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [FP_W-1:0] remainder_bits;
  logic            invalid_operation;

  modport source (output valid, output remainder_bits, output invalid_operation, input ready);
  modport sink   (input valid, input remainder_bits, input invalid_operation, output ready);
endinterface

>>> hw/rtl/double_floored_modulo.sv
// ----------------------------------------------------------------------------
// double_floored_modulo: binary64 floored modulo
// Truncated remainder by restoring shift-and-subtract, then a sign fix-up
// add of the divisor with round-to-nearest-even, on one shared subtractor.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | handshake
//  in_ch   | in  | dividend_bits, divisor_bits (64, 64) | valid/ready
//  out_ch  | out | remainder_bits (64), invalid_op (1)  | valid/ready
//
// One item at a time; in_ch.ready is high only while the sequencer is idle.
// Steps per item: check, normalize, the division loop with one subtract
//   per exponent step, pack, fix-up check, align, fix-up normalize and
//   round, then the done state.
// Specials (NaN, zero divisor, infinite dividend) go from check straight to done.
// Synchronous active-low reset returns to idle with no result pending.
// A result waiting on out_ch does not block the next transfer in; the
// sequencer only holds in its final state until the output register frees.
// ----------------------------------------------------------------------------
module double_floored_modulo import dfm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  dfm_in_if.sink   in_ch,
  dfm_out_if.source out_ch
);
`include "double_floored_modulo_defines.svh"

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_CHECK  = 11'b000_0000_0010,
    S_NORM   = 11'b000_0000_0100,
    S_DIV    = 11'b000_0000_1000,
    S_POST   = 11'b000_0001_0000,
    S_FIXCHK = 11'b000_0010_0000,
    S_ALIGN  = 11'b000_0100_0000,
    S_FNORM  = 11'b000_1000_0000,
    S_RND    = 11'b001_0000_0000,
    S_DONE   = 11'b010_0000_0000,
    S_SPARE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [FP_W-1:0]   a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic              inv_r, inv_nxt;
  logic [53:0]       mx_r, mx_nxt, my_r, my_nxt;
  logic signed [12:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [ALU_W-1:0]  acc_r, acc_nxt, bm_r, bm_nxt;
  logic [EXP_W-1:0]  d_r, d_nxt, e_r, e_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [FP_W-1:0]   out_rem_r, out_rem_nxt;
  logic              out_inv_r, out_inv_nxt;

  // shared subtractor
  logic [ALU_W-1:0] sub_a, sub_b, sub_diff;
  logic             sub_ge;

  dfm_sub u_sub (.op_a(sub_a), .op_b(sub_b), .diff(sub_diff), .ge(sub_ge));

  assign sub_a = (state_r == S_DIV) ? {2'b00, mx_r} : bm_r;
  assign sub_b = (state_r == S_DIV) ? {2'b00, my_r} : acc_r;

  // operand classification
  logic [MAG_W-1:0] ma, mb;
  logic             a_nan, b_nan, a_inf, b_inf;

  assign ma    = a_r[MAG_W-1:0];
  assign mb    = b_r[MAG_W-1:0];
  assign a_nan = ma > EXP_INF;
  assign b_nan = mb > EXP_INF;
  assign a_inf = ma == EXP_INF;
  assign b_inf = mb == EXP_INF;

  // raw unpack: subnormals keep exponent 1 and no hidden bit
  function automatic logic [EXP_W-1:0] raw_exp(input logic [FP_W-1:0] v);
    raw_exp = (v[62:52] == '0) ? 11'd1 : v[62:52];
  endfunction

  function automatic logic [52:0] raw_mant(input logic [FP_W-1:0] v);
    raw_mant = {(v[62:52] != '0), v[51:0]};
  endfunction

  logic [EXP_W-1:0] fx_er, fx_eb, fx_d;
  logic [53:0]      div_sel;
  logic             rnd_up;
  logic [53:0]      rnd_sum;
  logic [52:0]      rnd_mant;
  logic [EXP_W-1:0] rnd_exp;

  assign fx_er   = raw_exp(res_r);
  assign fx_eb   = raw_exp(b_r);
  assign fx_d    = fx_eb - fx_er;
  assign div_sel = sub_ge ? sub_diff[53:0] : mx_r;
  assign rnd_up  = acc_r[2] & (acc_r[1] | acc_r[0] | acc_r[3]);
  assign rnd_sum = {1'b0, acc_r[55:3]} + {53'd0, rnd_up};
  assign rnd_mant = rnd_sum[53] ? rnd_sum[53:1] : rnd_sum[52:0];
  assign rnd_exp  = rnd_sum[53] ? e_r + 11'd1 : e_r;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    inv_nxt       = inv_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    acc_nxt       = acc_r;
    bm_nxt        = bm_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_rem_nxt   = out_rem_r;
    out_inv_nxt   = out_inv_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          a_nxt     = in_ch.dividend_bits;
          b_nxt     = in_ch.divisor_bits;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        inv_nxt = 1'b0;
        if (a_nan || b_nan || a_inf || mb == '0) begin
          res_nxt   = QNAN_BITS;
          inv_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (b_inf || ma == '0 || ma < mb) begin
          res_nxt   = a_r;
          state_nxt = S_FIXCHK;
        end else if (ma == mb) begin
          res_nxt   = {a_r[63], 63'd0};
          state_nxt = S_FIXCHK;
        end else begin
          mx_nxt    = {1'b0, raw_mant(a_r)};
          my_nxt    = {1'b0, raw_mant(b_r)};
          ex_nxt    = signed'({2'b00, raw_exp(a_r)});
          ey_nxt    = signed'({2'b00, raw_exp(b_r)});
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        // bring subnormal mantissas up to the hidden-bit position
        if (!mx_r[52]) begin
          mx_nxt = {mx_r[52:0], 1'b0};
          ex_nxt = ex_r - 13'sd1;
        end else if (!my_r[52]) begin
          my_nxt = {my_r[52:0], 1'b0};
          ey_nxt = ey_r - 13'sd1;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (ex_r > ey_r) begin
          mx_nxt = {div_sel[52:0], 1'b0};
          ex_nxt = ex_r - 13'sd1;
        end else begin
          mx_nxt    = div_sel;
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        // renormalize, or denormalize below the minimum exponent (exact)
        if (mx_r == '0) begin
          res_nxt   = {a_r[63], 63'd0};
          state_nxt = S_FIXCHK;
        end else if (!mx_r[52] && ex_r > 13'sd1) begin
          mx_nxt = {mx_r[52:0], 1'b0};
          ex_nxt = ex_r - 13'sd1;
        end else if (ex_r < 13'sd1) begin
          mx_nxt = {1'b0, mx_r[53:1]};
          ex_nxt = ex_r + 13'sd1;
        end else begin
          res_nxt   = {a_r[63], (mx_r[52] ? ex_r[10:0] : 11'd0), mx_r[51:0]};
          state_nxt = S_FIXCHK;
        end
      end
      S_FIXCHK: begin
        if (res_r[62:0] == '0 || !(res_r[63] ^ b_r[63])) begin
          state_nxt = S_DONE;
        end else if (b_inf) begin
          res_nxt   = {b_r[63], EXP_ONES, 52'd0};
          state_nxt = S_DONE;
        end else begin
          // |r| < |b|: result is |b| - |r| with the sign of b
          bm_nxt = {raw_mant(b_r), 3'b000};
          e_nxt  = fx_eb;
          if (fx_d >= 11'(ALU_W)) begin
            acc_nxt = {{(ALU_W-1){1'b0}}, 1'b1};
            d_nxt   = '0;
          end else begin
            acc_nxt = {raw_mant(res_r), 3'b000};
            d_nxt   = fx_d;
          end
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (d_r != '0) begin
          acc_nxt = {1'b0, acc_r[ALU_W-1:1]} | {{(ALU_W-1){1'b0}}, acc_r[0]};
          d_nxt   = d_r - 11'd1;
        end else begin
          acc_nxt   = sub_diff;
          state_nxt = S_FNORM;
        end
      end
      S_FNORM: begin
        if (!acc_r[ALU_W-1] && e_r > 11'd1) begin
          acc_nxt = {acc_r[ALU_W-2:0], 1'b0};
          e_nxt   = e_r - 11'd1;
        end else begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        res_nxt   = {b_r[63], (rnd_mant[52] ? rnd_exp : 11'd0), rnd_mant[51:0]};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_rem_nxt   = res_r;
          out_inv_nxt   = inv_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    res_r     <= res_nxt;
    inv_r     <= inv_nxt;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    ex_r      <= ex_nxt;
    ey_r      <= ey_nxt;
    acc_r     <= acc_nxt;
    bm_r      <= bm_nxt;
    d_r       <= d_nxt;
    e_r       <= e_nxt;
    out_rem_r <= out_rem_nxt;
    out_inv_r <= out_inv_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.remainder_bits    = out_rem_r;
  assign out_ch.invalid_operation = out_inv_r;

  `DFM_ASSERT_NEXT(a_accept_check, in_ch.valid && in_ch.ready, state_r == S_CHECK)
  `DFM_ASSERT_IMPL(a_div_order, state_r == S_DIV, ex_r >= ey_r)
  `DFM_ASSERT_IMPL(a_inv_qnan, out_ch.valid && out_ch.invalid_operation,
                   out_ch.remainder_bits == QNAN_BITS)
endmodule

>>> hw/rtl/dfm_sub.sv
// ----------------------------------------------------------------------------
// dfm_sub: shared subtract/compare unit
// Difference of two unsigned words and an a >= b flag.
// ----------------------------------------------------------------------------
module dfm_sub import dfm_pkg::*; (
  input  logic [ALU_W-1:0] op_a,
  input  logic [ALU_W-1:0] op_b,
  output logic [ALU_W-1:0] diff,
  output logic             ge
);
  logic [ALU_W:0] wide;

  assign wide = {1'b0, op_a} - {1'b0, op_b};
  assign diff = wide[ALU_W-1:0];
  assign ge   = ~wide[ALU_W];
endmodule
